[src/utf8d_pkg.sv]
package utf8d_pkg;

  localparam int unsigned CP_W    = 31;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned PEND_W  = 3;

  // Result queue geometry.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Largest number of results one byte can produce.
  localparam int unsigned MAX_RES = 2;
  localparam int unsigned NUM_W   = $clog2(MAX_RES + 1);

  localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 16'hFFFF;

  // Payload masks of the lead bytes, by number of trailing bytes.
  localparam logic [BYTE_W-1:0] LEAD1_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h03;
  localparam logic [BYTE_W-1:0] LEAD5_MASK = 8'h01;

  typedef enum logic [1:0] {
    ST_CHAR     = 2'd0,
    ST_STRAY    = 2'd1,
    ST_BAD_LEAD = 2'd2,
    ST_END      = 2'd3
  } status_t;

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    status_t            status;
    logic [COUNT_W-1:0] char_count;
    logic               last_of_run;
  } result_t;

  // Results of one decoded byte, handed to the result queue.
  typedef struct packed {
    logic [NUM_W-1:0] num;
    result_t          r0;
    result_t          r1;
  } push_t;

endpackage

[src/utf8d_decode.sv]
module utf8d_decode (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic [utf8d_pkg::BYTE_W-1:0]    data_byte,
  input  logic                            end_of_string,
  input  logic [utf8d_pkg::COUNT_W-1:0]   max_chars,
  output utf8d_pkg::push_t                push
);
  import utf8d_pkg::*;

  logic [PEND_W-1:0]  pend_r, pend_nxt;
  logic [CP_W-1:0]    pv_r, pv_nxt;
  logic [COUNT_W-1:0] chars_r, chars_nxt;
  logic [CP_W-1:0]    pv_sh;
  logic               have_a;
  result_t            res_a;
  result_t            res_e;

  assign pv_sh = {pv_r[CP_W-7:0], data_byte[5:0]};

  always_comb begin
    pend_nxt  = pend_r;
    pv_nxt    = pv_r;
    chars_nxt = chars_r;
    have_a    = 1'b0;
    res_a     = '0;
    res_a.status = ST_CHAR;

    if (pend_r != '0) begin
      // Trailing byte: its top two bits are not checked.
      pend_nxt = pend_r - 3'd1;
      pv_nxt   = pv_sh;
      if (pend_r == 3'd1) begin
        chars_nxt        = chars_r + 16'd1;
        have_a           = 1'b1;
        res_a.code_point = pv_sh;
        res_a.char_count = chars_nxt;
        pv_nxt           = '0;
      end
    end else if (chars_r < max_chars) begin
      case (data_byte) inside
        [8'h00:8'h7F]: begin
          chars_nxt        = chars_r + 16'd1;
          have_a           = 1'b1;
          res_a.code_point = {23'd0, data_byte};
          res_a.char_count = chars_nxt;
        end
        [8'h80:8'hBF]: begin
          have_a           = 1'b1;
          res_a.status     = ST_STRAY;
          res_a.char_count = chars_r;
        end
        [8'hC0:8'hDF]: begin
          pend_nxt = 3'd1;
          pv_nxt   = {23'd0, data_byte & LEAD1_MASK};
        end
        [8'hE0:8'hEF]: begin
          pend_nxt = 3'd2;
          pv_nxt   = {23'd0, data_byte & LEAD2_MASK};
        end
        [8'hF0:8'hF7]: begin
          pend_nxt = 3'd3;
          pv_nxt   = {23'd0, data_byte & LEAD3_MASK};
        end
        [8'hF8:8'hFB]: begin
          pend_nxt = 3'd4;
          pv_nxt   = {23'd0, data_byte & LEAD4_MASK};
        end
        [8'hFC:8'hFD]: begin
          pend_nxt = 3'd5;
          pv_nxt   = {23'd0, data_byte & LEAD5_MASK};
        end
        default: begin
          chars_nxt        = chars_r + 16'd1;
          have_a           = 1'b1;
          res_a.status     = ST_BAD_LEAD;
          res_a.char_count = chars_nxt;
        end
      endcase
    end
    res_a.last_of_run = !end_of_string;

    res_e             = '0;
    res_e.status      = ST_END;
    res_e.char_count  = chars_nxt;
    res_e.last_of_run = 1'b1;

    // The string end drops any open sequence.
    if (end_of_string) begin
      pend_nxt  = '0;
      pv_nxt    = '0;
      chars_nxt = '0;
    end

    push.num = adv ? ({1'b0, have_a} + {1'b0, end_of_string}) : '0;
    push.r0  = have_a ? res_a : res_e;
    push.r1  = res_e;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= '0;
      pv_r    <= '0;
      chars_r <= '0;
    end else if (adv) begin
      pend_r  <= pend_nxt;
      pv_r    <= pv_nxt;
      chars_r <= chars_nxt;
    end
  end

`ifndef SYNTH
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 3'd5)
    else $error("trailing byte count out of range");

  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && end_of_string |=> pend_r == '0 && chars_r == '0 && pv_r == '0)
    else $error("state not cleared after string end");

  a_idle_pv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r == '0 |-> pv_r == '0)
    else $error("partial value left with no sequence open");
`endif

endmodule

[src/utf8d_queue.sv]
module utf8d_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  utf8d_pkg::push_t    push,
  output logic                room,
  output logic                out_valid,
  input  logic                out_stall,
  output utf8d_pkg::result_t  out_res
);
  import utf8d_pkg::*;

  result_t           q_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic [QPTR_W-1:0] wr_ptr_p1;
  logic              pop;

  assign wr_ptr_p1 = wr_ptr_r + 1'b1;
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;
  assign out_res   = q_r[rd_ptr_r];
  // Room for the largest number of results one byte can make.
  assign room      = count_r <= QCNT_W'(QDEPTH - MAX_RES);

  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(push.num);
  assign rd_ptr_nxt = rd_ptr_r + QPTR_W'(pop);
  assign count_nxt  = count_r + QCNT_W'(push.num) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      if (push.num != '0 && QPTR_W'(i) == wr_ptr_r) begin
        q_r[i] <= push.r0;
      end else if (push.num == NUM_W'(MAX_RES) && QPTR_W'(i) == wr_ptr_p1) begin
        q_r[i] <= push.r1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef SYNTH
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != '0 |-> count_r <= QCNT_W'(QDEPTH - MAX_RES))
    else $error("results pushed without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QPTR_W'(wr_ptr_r - rd_ptr_r) == QPTR_W'(count_r))
    else $error("queue pointers disagree with count");
`endif

endmodule

[src/utf8_to_code_point_decoder.sv]
// UTF-8 decoder for the original six-byte form. Each input item is one byte of a
// string; the byte flagged with in_end_of_string closes the string. A byte produces
// zero, one or two result items: a character (status 0), a stray continuation error
// (status 1), an invalid 0xFE/0xFF lead (status 2, code point 0, counted as a
// character), and, on the last byte of a string, a string-end item (status 3)
// carrying the final character count. out_last_of_run marks the final item made
// by a byte. Lead bytes and bytes inside a sequence make no result until the
// sequence completes; trailing bytes are not checked for their 10xxxxxx prefix.
// Once max_chars characters have been decoded, further bytes outside an open
// sequence are ignored. Rate: one byte per clock while the result queue has room for
// two results. The result port delivers one item per clock unless out_stall holds
// it, so a byte that both completes a character and ends the string puts two items
// on the output; a four-entry result queue absorbs this. An accepted byte is held in
// the input register, decoded from there into the result queue, and offered from
// the queue. Configuration through cfg_wr_en / cfg_wr_data sets max_chars (reset
// 65535) and is meant to be written while the decoder is idle.
module utf8_to_code_point_decoder (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           cfg_wr_en,
  input  logic [utf8d_pkg::COUNT_W-1:0]  cfg_wr_data,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [utf8d_pkg::BYTE_W-1:0]   in_data_byte,
  input  logic                           in_end_of_string,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [utf8d_pkg::CP_W-1:0]     out_code_point,
  output logic [1:0]                     out_status,
  output logic [utf8d_pkg::COUNT_W-1:0]  out_char_count,
  output logic                           out_last_of_run
);
  import utf8d_pkg::*;

  logic [COUNT_W-1:0] max_chars_r;

  // Input register: holds one byte until the result queue has room for
  // everything that byte can produce.
  logic              in_valid_r;
  logic [BYTE_W-1:0] byte_r;
  logic              eos_r;

  logic    room;
  logic    adv;
  push_t   push;
  result_t out_res;

  // The byte in the input register moves on whenever the queue can take
  // two results; the stall depends on registered state only.
  assign adv      = in_valid_r && room;
  assign in_stall = in_valid_r && !room;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_chars_r <= MAX_CHARS_RESET;
    end else if (cfg_wr_en) begin
      max_chars_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  // Payload needs no reset; it is loaded along with the valid bit.
  always_ff @(posedge clk) begin
    if (!in_stall) begin
      byte_r <= in_data_byte;
      eos_r  <= in_end_of_string;
    end
  end

  // Decoder state and the per-byte decision logic.
  utf8d_decode u_decode (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .data_byte     (byte_r),
    .end_of_string (eos_r),
    .max_chars     (max_chars_r),
    .push          (push)
  );

  // Result registers, organized as a small queue so that two results from
  // one byte never stall the input side for long.
  utf8d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_code_point  = out_res.code_point;
  assign out_status      = out_res.status;
  assign out_char_count  = out_res.char_count;
  assign out_last_of_run = out_res.last_of_run;

`ifndef SYNTH
  a_adv_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> room && in_valid_r)
    else $error("byte decoded without queue room");

  a_stalled_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> in_valid_r && $stable(byte_r) && $stable(eos_r))
    else $error("held byte changed while stalled");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_END |-> out_last_of_run)
    else $error("string end result not marked last");
`endif

endmodule

[dv/testbench.sv]
// Self-checking bench for the UTF-8 decoder. Bytes are pushed into the input
// channel one item at a time, and a behavioral decoder inside the bench works
// out which result items each accepted byte must produce. Those go into an
// in-order queue, and every result item taken from the block is compared
// against the oldest entry, field by field.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import utf8d_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned ITEM_TARGET   = 1500;
  localparam int unsigned DIRECTED_ROWS = 26;

  // One row of the directed table. When has_typed is set, the row makes
  // exactly one result item, and that item is written out by hand.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_string;
    bit          has_typed;
    logic [30:0] code_point;
    status_t     status;
    logic [15:0] char_count;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_end_of_string;
  logic        out_valid;
  logic        out_stall;
  logic [30:0] out_code_point;
  logic [1:0]  out_status;
  logic [15:0] out_char_count;
  logic        out_last_of_run;

  // Decoder state as the bench sees it.
  logic [2:0]  seq_left;
  logic [30:0] seq_value;
  logic [15:0] char_total;
  logic [15:0] char_limit;

  // Result items that the block still owes, oldest first.
  result_t queued_decodes [$];
  result_t oldest_decode;

  int unsigned fail_count;
  int unsigned counted_items;
  int unsigned burst_left;
  int unsigned cycle_count;
  bit          gaps_on;

  // The directed rows walk the extremes: the lowest and highest single-byte
  // characters, both ends of the stray continuation range, both invalid
  // leads, sequences of three to six bytes, a trailing byte with a wrong
  // prefix, the largest six-byte code point and a string cut off
  // mid-sequence.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, 1'b1, 31'h0,  ST_CHAR,     16'd1},
    '{8'h7F, 1'b0, 1'b1, 31'h7F, ST_CHAR,     16'd2},
    '{8'h80, 1'b0, 1'b1, 31'h0,  ST_STRAY,    16'd2},
    '{8'hBF, 1'b0, 1'b1, 31'h0,  ST_STRAY,    16'd2},
    '{8'hFE, 1'b0, 1'b1, 31'h0,  ST_BAD_LEAD, 16'd3},
    '{8'hFF, 1'b0, 1'b1, 31'h0,  ST_BAD_LEAD, 16'd4},
    // Three-byte sequence whose trailing bytes lack the 10 prefix.
    '{8'hE2, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'h02, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hC3, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    // Four-byte sequence.
    '{8'hF4, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'h8F, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    // Five-byte sequence.
    '{8'hF8, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'h88, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'h80, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'h80, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'h80, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    // Six-byte sequence with every payload bit set, closing the string.
    '{8'hFD, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b1, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    // A string that ends inside a sequence: only the end item, count zero.
    '{8'hEF, 1'b0, 1'b0, 31'h0,  ST_CHAR,     16'd0},
    '{8'hBF, 1'b1, 1'b1, 31'h0,  ST_END,      16'd0}
  };

  utf8_to_code_point_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_code_point   (out_code_point),
    .out_status       (out_status),
    .out_char_count   (out_char_count),
    .out_last_of_run  (out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic result_t make_decode(input logic [30:0] cp, input status_t st,
                                          input logic [15:0] cnt);
    result_t r;
    r.code_point  = cp;
    r.status      = st;
    r.char_count  = cnt;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  // Advances the bench's copy of the decoder by one accepted byte and queues
  // the result items it makes. A typed row queues its hand-written item in
  // place of the computed one, while the state still moves on as usual.
  // With the limit reached and nothing open, the byte itself is dropped.
  task automatic decode_byte(input logic [7:0] b, input logic eos, input bit use_typed,
                             input result_t typed_res);
    result_t     made [2];
    int unsigned n;
    n = 0;
    if (seq_left != 0) begin
      // Inside a sequence every byte is a trailing byte, prefix unchecked.
      seq_value = {seq_value[24:0], b[5:0]};
      seq_left  = seq_left - 3'd1;
      if (seq_left == 0) begin
        char_total = char_total + 16'd1;
        made[n]    = make_decode(seq_value, ST_CHAR, char_total);
        n++;
        seq_value  = '0;
      end
    end else if (char_total < char_limit) begin
      if (b[7] == 1'b0) begin
        char_total = char_total + 16'd1;
        made[n]    = make_decode({23'd0, b}, ST_CHAR, char_total);
        n++;
      end else if (b[7:6] == 2'b10) begin
        made[n] = make_decode('0, ST_STRAY, char_total);
        n++;
      end else if (b >= 8'hFE) begin
        char_total = char_total + 16'd1;
        made[n]    = make_decode('0, ST_BAD_LEAD, char_total);
        n++;
      end else if (b[5] == 1'b0) begin
        seq_left  = 3'd1;
        seq_value = {23'd0, b & LEAD1_MASK};
      end else if (b[4] == 1'b0) begin
        seq_left  = 3'd2;
        seq_value = {23'd0, b & LEAD2_MASK};
      end else if (b[3] == 1'b0) begin
        seq_left  = 3'd3;
        seq_value = {23'd0, b & LEAD3_MASK};
      end else if (b[2] == 1'b0) begin
        seq_left  = 3'd4;
        seq_value = {23'd0, b & LEAD4_MASK};
      end else begin
        seq_left  = 3'd5;
        seq_value = {23'd0, b & LEAD5_MASK};
      end
    end

    if (eos) begin
      made[n]    = make_decode('0, ST_END, char_total);
      n++;
      seq_left   = '0;
      seq_value  = '0;
      char_total = '0;
    end

    if (use_typed) begin
      typed_res.last_of_run = 1'b1;
      queued_decodes.push_back(typed_res);
    end else if (n > 0) begin
      made[n-1].last_of_run = 1'b1;
      for (int unsigned i = 0; i < n; i++) begin
        queued_decodes.push_back(made[i]);
      end
    end
  endtask

  // Offers one byte and waits for the block to take it. Valid is left high,
  // so the next call moves straight on to the following item.
  task automatic offer_byte(input logic [7:0] b, input logic eos, input bit use_typed,
                            input result_t typed_res);
    if (burst_left == 0) begin
      if (gaps_on) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid         <= 1'b1;
    in_data_byte     <= b;
    in_end_of_string <= eos;
    do begin
      @(posedge clk);
    end while (in_stall !== 1'b0);
    decode_byte(b, eos, use_typed, typed_res);
    counted_items++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (queued_decodes.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // The limit is only changed with the block idle. A lead byte makes no
  // result item, so a settling wait after draining lets it be absorbed first.
  task automatic set_char_limit(input logic [15:0] limit);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= limit;
    char_limit   = limit;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Builds one string, mostly well-formed characters with random payloads,
  // salted with errors and noise, and sometimes cut off inside a sequence.
  task automatic send_random_string();
    logic [7:0]  bytes_q [$];
    int unsigned nchars;
    int unsigned kind;
    int unsigned trail;
    logic [7:0]  lead;
    result_t     none;
    none   = '0;
    nchars = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
    for (int unsigned c = 0; c < nchars; c++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        bytes_q.push_back(8'($urandom_range(0, 127)));
      end else if (kind < 80 || c == nchars - 1 && $urandom_range(0, 9) == 0) begin
        trail = $urandom_range(1, 5);
        lead  = 8'($urandom);
        case (trail)
          1: lead = {3'b110, lead[4:0]};
          2: lead = {4'b1110, lead[3:0]};
          3: lead = {5'b11110, lead[2:0]};
          4: lead = {6'b111110, lead[1:0]};
          default: lead = {7'b1111110, lead[0]};
        endcase
        bytes_q.push_back(lead);
        // The last character may lose part of its tail, leaving the
        // sequence open when the string ends.
        if (c == nchars - 1 && $urandom_range(0, 3) == 0) begin
          trail = $urandom_range(0, trail - 1);
        end
        for (int unsigned t = 0; t < trail; t++) begin
          if ($urandom_range(0, 9) == 0) begin
            bytes_q.push_back(8'($urandom));
          end else begin
            bytes_q.push_back({2'b10, 6'($urandom)});
          end
        end
      end else if (kind < 88) begin
        bytes_q.push_back({2'b10, 6'($urandom)});
      end else if (kind < 92) begin
        bytes_q.push_back({7'b1111111, 1'($urandom)});
      end else begin
        bytes_q.push_back(8'($urandom));
      end
    end
    foreach (bytes_q[i]) begin
      // Now and then the sender holds off until the block has caught up.
      if ($urandom_range(0, 79) == 0) begin
        drain_results();
      end
      offer_byte(bytes_q[i], i == bytes_q.size() - 1, 1'b0, none);
    end
  endtask

  // The receiver runs on a pattern of its own: open stretches, random
  // stalls, solid stalls and alternating stalls, each for a random length.
  initial begin
    int unsigned mode;
    int unsigned span;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = (mode == 2) ? $urandom_range(1, 8) : $urandom_range(1, 60);
      for (int unsigned k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom);
          2: out_stall <= 1'b1;
          default: out_stall <= k[0];
        endcase
      end
    end
  end

  // Every result item the block hands over is checked against the oldest
  // expectation still waiting.
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (queued_decodes.size() == 0) begin
        $display("%0t: result item with none expected: cp=%h status=%0d count=%0d last=%0b",
                 $time, out_code_point, out_status, out_char_count, out_last_of_run);
        fail_count++;
      end else begin
        oldest_decode = queued_decodes.pop_front();
        if (out_code_point !== oldest_decode.code_point ||
            out_status !== oldest_decode.status ||
            out_char_count !== oldest_decode.char_count ||
            out_last_of_run !== oldest_decode.last_of_run) begin
          $display("%0t: mismatch: expected %h/%0d/%0d/%0b, got %h/%0d/%0d/%0b",
                   $time, oldest_decode.code_point, oldest_decode.status,
                   oldest_decode.char_count, oldest_decode.last_of_run,
                   out_code_point, out_status, out_char_count, out_last_of_run);
          fail_count++;
        end
      end
    end
  end

  // A hang anywhere ends the run here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [15:0] limits [7];
    result_t     typed;
    result_t     none;
    none             = '0;
    fail_count       = 0;
    counted_items    = 0;
    burst_left       = 0;
    gaps_on          = 1'b1;
    rst_n           <= 1'b0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    in_valid        <= 1'b0;
    in_data_byte    <= '0;
    in_end_of_string <= 1'b0;
    seq_left         = '0;
    seq_value        = '0;
    char_total       = '0;
    char_limit       = MAX_CHARS_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run at the reset value of the limit.
    for (int unsigned r = 0; r < DIRECTED_ROWS; r++) begin
      typed = make_decode(directed_rows[r].code_point, directed_rows[r].status,
                          directed_rows[r].char_count);
      offer_byte(directed_rows[r].data_byte, directed_rows[r].end_of_string,
                 directed_rows[r].has_typed, typed);
    end

    // A sequence opened under one limit must still complete after the limit
    // drops to a value the count has already reached.
    set_char_limit(16'd2);
    offer_byte(8'h41, 1'b0, 1'b0, none);
    offer_byte(8'hE2, 1'b0, 1'b0, none);
    set_char_limit(16'd1);
    offer_byte(8'h82, 1'b0, 1'b0, none);
    offer_byte(8'hAC, 1'b1, 1'b0, none);

    // Random part: rounds of phases over several limits, both extremes
    // among them, until enough bytes have been sent.
    while (counted_items < ITEM_TARGET) begin
      limits = '{16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3,
                 16'($urandom_range(4, 15)), 16'($urandom_range(16, 400))};
      foreach (limits[p]) begin
        set_char_limit(limits[p]);
        // Some phases run with the sender never idling.
        gaps_on = ($urandom_range(0, 2) != 0);
        for (int unsigned s = 0; s < 8 && counted_items < ITEM_TARGET; s++) begin
          send_random_string();
        end
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
